/* rtl/pea_pkg.sv */
// Shared types and constants for the positional encoding adder.
// No dependencies; every other file imports this package.
package pea_pkg;

  localparam int MAX_DEPTH = 1024;
  localparam int DEPTH_W   = 11;
  localparam int POS_W     = 12;
  localparam int K_W       = 9;
  localparam int VAL_W     = 32;

  // Q30 constants
  localparam logic [30:0] Q_ONE     = 31'h4000_0000;
  localparam logic [33:0] LOG2_TENK = 34'd14267572527;
  localparam logic [29:0] LN2       = 30'd744261118;
  localparam logic [30:0] HALF_PI   = 31'd1686629713;
  localparam logic [32:0] TWO_PI    = 33'd6746518852;
  localparam logic [9:0]  ANG_RECIP = 10'((64'd1 << 42) / 64'd6746518852);

  // divider: 44-bit dividend, 4 quotient bits per stage
  localparam int NUM_W      = 44;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = NUM_W / DIV_STEP;

  localparam int N_EXP = 12;
  localparam int N_COS = 7;
  localparam int N_SIN = 6;

  localparam logic [7:0] EXP_DEN [N_EXP] = '{8'd12, 8'd11, 8'd10, 8'd9, 8'd8, 8'd7,
                                             8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1};
  localparam logic [32:0] EXP_RECIP [N_EXP] = '{
    33'((64'd1 << 32) / 64'd12), 33'((64'd1 << 32) / 64'd11),
    33'((64'd1 << 32) / 64'd10), 33'((64'd1 << 32) / 64'd9),
    33'((64'd1 << 32) / 64'd8),  33'((64'd1 << 32) / 64'd7),
    33'((64'd1 << 32) / 64'd6),  33'((64'd1 << 32) / 64'd5),
    33'((64'd1 << 32) / 64'd4),  33'((64'd1 << 32) / 64'd3),
    33'((64'd1 << 32) / 64'd2),  33'((64'd1 << 32) / 64'd1)};

  localparam logic [7:0] COS_DEN [N_COS] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [32:0] COS_RECIP [N_COS] = '{
    33'((64'd1 << 32) / 64'd182), 33'((64'd1 << 32) / 64'd132),
    33'((64'd1 << 32) / 64'd90),  33'((64'd1 << 32) / 64'd56),
    33'((64'd1 << 32) / 64'd30),  33'((64'd1 << 32) / 64'd12),
    33'((64'd1 << 32) / 64'd2)};

  localparam logic [7:0] SIN_DEN [N_SIN] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [32:0] SIN_RECIP [N_SIN] = '{
    33'((64'd1 << 32) / 64'd156), 33'((64'd1 << 32) / 64'd110),
    33'((64'd1 << 32) / 64'd72),  33'((64'd1 << 32) / 64'd42),
    33'((64'd1 << 32) / 64'd20),  33'((64'd1 << 32) / 64'd6)};

  // per-word data riding along the pipeline
  typedef struct packed {
    logic [VAL_W-1:0]   ve;
    logic [VAL_W-1:0]   vo;
    logic               fault;
    logic [POS_W-1:0]   pos;
    logic [DEPTH_W-1:0] d;
    logic [3:0]         nsh;
    logic [1:0]         quad;
    logic [30:0]        y;
  } side_t;

endpackage

/* rtl/pea_in_if.sv */
// Input channel: valid/ready handshake carrying one embedding pair word.
// Depends on pea_pkg.
interface pea_in_if import pea_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value_even;
  logic signed [VAL_W-1:0] value_odd;
  logic [POS_W-1:0]        position;
  logic [K_W-1:0]          pair_index;

  modport source (output valid, value_even, value_odd, position, pair_index, input ready);
  modport sink   (input valid, value_even, value_odd, position, pair_index, output ready);
endinterface

/* rtl/pea_out_if.sv */
// Output channel: valid/ready handshake carrying one result word.
// Depends on pea_pkg.
interface pea_out_if import pea_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sum_even;
  logic signed [VAL_W-1:0] sum_odd;
  logic                    index_fault;

  modport source (output valid, sum_even, sum_odd, index_fault, input ready);
  modport sink   (input valid, sum_even, sum_odd, index_fault, output ready);
endinterface

/* rtl/pea_div_stage.sv */
// One stage of the pipelined restoring divider, DIV_STEP quotient bits.
// Depends on pea_pkg.
module pea_div_stage import pea_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vin,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEPTH_W-1:0] rem,
  input  side_t              si,
  output logic               vout,
  output logic [NUM_W-1:0]   num_out,
  output logic [DEPTH_W-1:0] rem_out,
  output side_t              so
);

  logic [NUM_W-1:0]   num_next;
  logic [DEPTH_W-1:0] rem_next;

  always_comb begin
    logic [DEPTH_W:0] r12;
    num_next = num;
    rem_next = rem;
    for (int i = 0; i < DIV_STEP; i++) begin
      r12      = {rem_next, num_next[NUM_W-1]};
      num_next = {num_next[NUM_W-2:0], 1'b0};
      if (r12 >= {1'b0, si.d}) begin
        r12         = r12 - {1'b0, si.d};
        num_next[0] = 1'b1;
      end
      rem_next = r12[DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_out <= num_next;
      rem_out <= rem_next;
      so      <= si;
    end
  end

endmodule

/* rtl/pea_horner_step.sv */
// One Horner step t' = 1 - min(1, (z*t >> 30) / den), Q30, three stages.
// Depends on pea_pkg; den and recip are tied to package constants.
module pea_horner_step import pea_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vin,
  input  logic [31:0] z,
  input  logic [30:0] t,
  input  side_t       si,
  input  logic [7:0]  den,
  input  logic [32:0] recip,
  output logic        vout,
  output logic [31:0] z_out,
  output logic [30:0] t_out,
  output side_t       so
);

  logic        v1, v2;
  logic [31:0] z1, z2;
  side_t       s1, s2;
  logic [31:0] prod1;
  logic [31:0] prod2;
  logic [31:0] qe2;

  logic [62:0] mul_a;
  logic [64:0] mul_b;
  logic [39:0] r3;
  logic [31:0] q3;
  logic [30:0] p3;

  assign mul_a = 63'(z) * 63'(t);
  assign mul_b = 65'(prod1) * 65'(recip);

  // reciprocal estimate is low by at most one
  always_comb begin
    r3 = 40'(prod2) - 40'(qe2) * 40'(den);
    q3 = qe2 + 32'(r3 >= 40'(den));
    p3 = (q3 > 32'(Q_ONE)) ? Q_ONE : q3[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      v2   <= v1;
      vout <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= mul_a[61:30];
      z1    <= z;
      s1    <= si;
      prod2 <= prod1;
      qe2   <= mul_b[63:32];
      z2    <= z1;
      s2    <= s1;
      t_out <= Q_ONE - p3;
      z_out <= z2;
      so    <= s2;
    end
  end

endmodule

/* rtl/pea_freq.sv */
// Frequency path: index check, exponent by pipelined division, 2^-e by
// Taylor series and shift. Depends on pea_pkg, pea_div_stage, pea_horner_step.
module pea_freq import pea_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vin,
  input  logic [VAL_W-1:0]   value_even,
  input  logic [VAL_W-1:0]   value_odd,
  input  logic [POS_W-1:0]   position,
  input  logic [K_W-1:0]     pair_index,
  input  logic [DEPTH_W-1:0] depth,
  output logic               vout,
  output logic [30:0]        freq,
  output side_t              so
);

  logic               v0, v1, vx;
  side_t              s0, s1, sx;
  side_t              sx_next;
  logic [K_W:0]       k2_0;
  logic [NUM_W-1:0]   num1;
  logic [29:0]        x;
  logic [DEPTH_W-1:0] dsat;
  logic [K_W:0]       k2;
  logic [33:0]        e;
  logic [59:0]        xprod;

  logic               dv   [DIV_STAGES+1];
  logic [NUM_W-1:0]   dnum [DIV_STAGES+1];
  logic [DEPTH_W-1:0] drem [DIV_STAGES+1];
  side_t              dside[DIV_STAGES+1];

  logic        hv [N_EXP+1];
  logic [31:0] hz [N_EXP+1];
  logic [30:0] ht [N_EXP+1];
  side_t       hs [N_EXP+1];

  assign dsat  = (depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : depth;
  assign k2    = {pair_index, 1'b0};
  assign e     = dnum[DIV_STAGES][33:0];
  assign xprod = 60'(e[29:0]) * 60'(LN2);

  // integer part of the exponent rides along as the final shift
  always_comb begin
    sx_next     = dside[DIV_STAGES];
    sx_next.nsh = e[33:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      vx   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v0   <= vin;
      v1   <= v0;
      vx   <= dv[DIV_STAGES];
      vout <= hv[N_EXP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0.ve    <= value_even;
      s0.vo    <= value_odd;
      s0.fault <= {1'b0, k2} >= dsat;
      s0.pos   <= position;
      s0.d     <= dsat;
      s0.nsh   <= '0;
      s0.quad  <= '0;
      s0.y     <= '0;
      k2_0     <= k2;
      num1     <= NUM_W'(k2_0) * NUM_W'(LOG2_TENK);
      s1       <= s0;
      x        <= xprod[59:30];
      sx       <= sx_next;
      freq     <= ht[N_EXP] >> hs[N_EXP].nsh;
      so       <= hs[N_EXP];
    end
  end

  assign dv[0]    = v1;
  assign dnum[0]  = num1;
  assign drem[0]  = '0;
  assign dside[0] = s1;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    pea_div_stage u_div (
      .clk, .rst, .en,
      .vin(dv[i]), .num(dnum[i]), .rem(drem[i]), .si(dside[i]),
      .vout(dv[i+1]), .num_out(dnum[i+1]), .rem_out(drem[i+1]), .so(dside[i+1])
    );
  end

  assign hv[0] = vx;
  assign hz[0] = {2'b00, x};
  assign ht[0] = Q_ONE;
  assign hs[0] = sx;

  for (genvar i = 0; i < N_EXP; i++) begin : g_exp
    pea_horner_step u_step (
      .clk, .rst, .en,
      .vin(hv[i]), .z(hz[i]), .t(ht[i]), .si(hs[i]),
      .den(EXP_DEN[i]), .recip(EXP_RECIP[i]),
      .vout(hv[i+1]), .z_out(hz[i+1]), .t_out(ht[i+1]), .so(hs[i+1])
    );
  end

endmodule

/* rtl/pea_trig.sv */
// Angle path: position * frequency mod 2*pi, quadrant split, sine and cosine
// series, quadrant mapping. Depends on pea_pkg and pea_horner_step.
module pea_trig import pea_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vin,
  input  logic [30:0]        freq,
  input  side_t              si,
  output logic               vout,
  output logic signed [17:0] se,
  output logic signed [17:0] ce,
  output side_t              so
);

  logic        v1, v2, v3, v4, v5;
  side_t       s1, s2, s3, s4, s5;
  side_t       s4_next;
  logic [42:0] p1, p2;
  logic [9:0]  qe2;
  logic [32:0] ang3;
  logic [31:0] y2_5;

  logic [52:0] qprod;
  logic [43:0] r3;
  logic [1:0]  quad4;
  logic [32:0] y4;
  logic [61:0] ysq;

  assign qprod = 53'(p1) * 53'(ANG_RECIP);
  assign r3    = 44'(p2) - 44'(qe2) * 44'(TWO_PI);
  assign ysq   = 62'(s4.y) * 62'(s4.y);

  always_comb begin
    if (ang3 >= 33'(3) * 33'(HALF_PI)) begin
      quad4 = 2'd3;
      y4    = ang3 - 33'(3) * 33'(HALF_PI);
    end else if (ang3 >= 33'(2) * 33'(HALF_PI)) begin
      quad4 = 2'd2;
      y4    = ang3 - 33'(2) * 33'(HALF_PI);
    end else if (ang3 >= 33'(HALF_PI)) begin
      quad4 = 2'd1;
      y4    = ang3 - 33'(HALF_PI);
    end else begin
      quad4 = 2'd0;
      y4    = ang3;
    end
  end

  always_comb begin
    s4_next      = s3;
    s4_next.quad = quad4;
    s4_next.y    = y4[30:0];
  end

  // cosine and sine series run side by side on y^2
  logic        cv [N_COS+1];
  logic [31:0] cz [N_COS+1];
  logic [30:0] ct [N_COS+1];
  side_t       cs [N_COS+1];
  logic        sv [N_SIN+1];
  logic [31:0] sz [N_SIN+1];
  logic [30:0] st [N_SIN+1];
  side_t       ss [N_SIN+1];

  assign cv[0] = v5;
  assign cz[0] = y2_5;
  assign ct[0] = Q_ONE;
  assign cs[0] = s5;
  assign sv[0] = v5;
  assign sz[0] = y2_5;
  assign st[0] = Q_ONE;
  assign ss[0] = s5;

  for (genvar i = 0; i < N_COS; i++) begin : g_cos
    pea_horner_step u_step (
      .clk, .rst, .en,
      .vin(cv[i]), .z(cz[i]), .t(ct[i]), .si(cs[i]),
      .den(COS_DEN[i]), .recip(COS_RECIP[i]),
      .vout(cv[i+1]), .z_out(cz[i+1]), .t_out(ct[i+1]), .so(cs[i+1])
    );
  end

  for (genvar i = 0; i < N_SIN; i++) begin : g_sin
    pea_horner_step u_step (
      .clk, .rst, .en,
      .vin(sv[i]), .z(sz[i]), .t(st[i]), .si(ss[i]),
      .den(SIN_DEN[i]), .recip(SIN_RECIP[i]),
      .vout(sv[i+1]), .z_out(sz[i+1]), .t_out(st[i+1]), .so(ss[i+1])
    );
  end

  // sine tail: times y, clamp, round; three stages to match the cosine step
  logic        tv1, tv2, tv3;
  logic [60:0] sp1;
  logic [16:0] ms2, ms3;
  logic [30:0] s_clamp;
  logic [31:0] s_rnd;
  logic [31:0] c_rnd;
  logic [16:0] mc;

  assign s_clamp = (sp1[60:30] > Q_ONE) ? Q_ONE : sp1[60:30];
  assign s_rnd   = 32'(s_clamp) + 32'(14'h2000);
  assign c_rnd   = 32'(ct[N_COS]) + 32'(14'h2000);
  assign mc      = c_rnd[30:14];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      tv1 <= 1'b0; tv2 <= 1'b0; tv3 <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      tv1  <= sv[N_SIN];
      tv2  <= tv1;
      tv3  <= tv2;
      vout <= cv[N_COS] & tv3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1      <= 43'(si.pos) * 43'(freq);
      s1      <= si;
      p2      <= p1;
      qe2     <= qprod[51:42];
      s2      <= s1;
      ang3    <= (r3 >= 44'(TWO_PI)) ? 33'(r3 - 44'(TWO_PI)) : r3[32:0];
      s3      <= s2;
      s4      <= s4_next;
      y2_5    <= ysq[61:30];
      s5      <= s4;
      sp1     <= 61'(st[N_SIN]) * 61'(ss[N_SIN].y);
      ms2     <= s_rnd[30:14];
      ms3     <= ms2;
      so      <= cs[N_COS];
      case (cs[N_COS].quad)
        2'd0: begin
          se <= 18'(ms3);
          ce <= 18'(mc);
        end
        2'd1: begin
          se <= 18'(mc);
          ce <= -18'(ms3);
        end
        2'd2: begin
          se <= -18'(ms3);
          ce <= -18'(mc);
        end
        default: begin
          se <= -18'(mc);
          ce <= 18'(ms3);
        end
      endcase
    end
  end

endmodule

/* rtl/sinusoidal_positional_encoding_add.sv */
// Top level of the sinusoidal positional encoding adder.
// Depends on pea_pkg, pea_in_if, pea_out_if, pea_freq, pea_trig.
//
// Adds sin(angle) to value_even and cos(angle) to value_odd, where
// angle = position * 10000^(-2k/model_depth) mod 2*pi, all in fixed point
// (Q30 inside, Q16.16 at the ports, sums saturated to 32 bits). A pair index
// with 2k >= model_depth (depth capped at 1024) sets index_fault and passes
// the values through unchanged. The block is a pipeline: one word is taken
// every cycle unless the pipe holds. Its stages: 2 front stages, 11 divider
// stages of 4 quotient bits, 1 log stage, 12 three-stage exponential series
// steps, 1 shift, 5 angle stages, 7 three-stage cosine steps with the sine
// path alongside, 1 mapping stage and 1 output register. The whole pipe
// advances together and holds while the output register is full and not
// taken. model_depth resets to 512 and must only be written while no word
// is in flight.
module sinusoidal_positional_encoding_add import pea_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [DEPTH_W-1:0] cfg_data,
  pea_in_if.sink             din,
  pea_out_if.source          dout
);

  logic [DEPTH_W-1:0] model_depth;
  logic               en;
  logic               fv;
  logic [30:0]        freq;
  side_t              fs;
  logic               tv;
  logic signed [17:0] se, ce;
  side_t              ts;
  logic signed [32:0] sum_e, sum_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_depth <= DEPTH_W'(512);
    end else if (cfg_we) begin
      model_depth <= cfg_data;
    end
  end

  // pipe moves whenever the output register is empty or being drained
  assign en        = ~dout.valid | dout.ready;
  assign din.ready = en;

  pea_freq u_freq (
    .clk, .rst, .en,
    .vin(din.valid),
    .value_even(din.value_even),
    .value_odd(din.value_odd),
    .position(din.position),
    .pair_index(din.pair_index),
    .depth(model_depth),
    .vout(fv), .freq(freq), .so(fs)
  );

  pea_trig u_trig (
    .clk, .rst, .en,
    .vin(fv), .freq(freq), .si(fs),
    .vout(tv), .se(se), .ce(ce), .so(ts)
  );

  assign sum_e = {ts.ve[31], ts.ve} + 33'(se);
  assign sum_o = {ts.vo[31], ts.vo} + 33'(ce);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= tv;
    end
  end

  // saturate on overflow: top two bits of the 33-bit sum disagree
  always_ff @(posedge clk) begin
    if (en) begin
      dout.index_fault <= ts.fault;
      if (ts.fault) begin
        dout.sum_even <= ts.ve;
        dout.sum_odd  <= ts.vo;
      end else begin
        dout.sum_even <= (sum_e[32] != sum_e[31]) ?
                         {sum_e[32], {31{~sum_e[32]}}} : sum_e[31:0];
        dout.sum_odd  <= (sum_o[32] != sum_o[31]) ?
                         {sum_o[32], {31{~sum_o[32]}}} : sum_o[31:0];
      end
    end
  end

endmodule
